FILE: design/sle_pkg.sv
`default_nettype none

package sle_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int LEN_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = 6;
  localparam int CALC_W       = (LEN_W > 7) ? LEN_W + 1 : 8;
  localparam logic [CNT_W-1:0] MAX_COUNT = {CNT_W{1'b1}};

  localparam logic [7:0] REL_BIT    = 8'h80;
  localparam logic [7:0] CODE_MASK  = 8'h7F;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_LINE     = 2'd1;
  localparam logic [1:0] KIND_NOTREADY = 2'd2;
  localparam logic [1:0] KIND_EMPTY    = 2'd3;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
    logic [6:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [CNT_W-1:0] line_count;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ECHO, S_BS1, S_BS2, S_BS3,
    S_NOTRDY, S_EMPTY, S_RD_ADDR, S_RD_DATA
  } state_e;

  typedef enum logic [1:0] { ACT_NONE, ACT_BKSP, ACT_ECHO } act_e;
  typedef enum logic [1:0] { RD_NOTREADY, RD_EMPTY, RD_STREAM } rd_e;
  typedef enum logic [2:0] {
    SRC_CHAR, SRC_BS, SRC_SPACE, SRC_NOTREADY, SRC_EMPTY, SRC_LINE
  } src_e;

  typedef struct packed {
    logic accept;
    logic commit;
    logic mem_rd;
    logic out_load;
    src_e out_src;
    logic out_last;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic op;
    act_e act;
    rd_e  rd;
    logic idx_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] map_plain(input logic [6:0] code);
    logic [7:0] c;
    unique case (code)
      7'h01: c = 8'h1B;  7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;
      7'h05: c = 8'h34;  7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;
      7'h09: c = 8'h38;  7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;  7'h0E: c = 8'h08;  7'h0F: c = 8'h09;  7'h10: c = 8'h71;
      7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;  7'h14: c = 8'h74;
      7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;  7'h18: c = 8'h6F;
      7'h19: c = 8'h70;  7'h1A: c = 8'h5B;  7'h1B: c = 8'h5D;  7'h1C: c = 8'h0A;
      7'h1E: c = 8'h61;  7'h1F: c = 8'h73;  7'h20: c = 8'h64;  7'h21: c = 8'h66;
      7'h22: c = 8'h67;  7'h23: c = 8'h68;  7'h24: c = 8'h6A;  7'h25: c = 8'h6B;
      7'h26: c = 8'h6C;  7'h27: c = 8'h3B;  7'h28: c = 8'h27;  7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;  7'h2C: c = 8'h7A;  7'h2D: c = 8'h78;  7'h2E: c = 8'h63;
      7'h2F: c = 8'h76;  7'h30: c = 8'h62;  7'h31: c = 8'h6E;  7'h32: c = 8'h6D;
      7'h33: c = 8'h2C;  7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letters of the shifted table are the upper-case form of the plain table.
  function automatic logic [7:0] map_shifted(input logic [6:0] code);
    logic [7:0] p;
    logic [7:0] c;
    p = map_plain(code);
    unique case (code)
      7'h02: c = 8'h21;  7'h03: c = 8'h40;  7'h04: c = 8'h23;  7'h05: c = 8'h24;
      7'h06: c = 8'h25;  7'h07: c = 8'h5E;  7'h08: c = 8'h26;  7'h09: c = 8'h2A;
      7'h0A: c = 8'h28;  7'h0B: c = 8'h29;  7'h0C: c = 8'h5F;  7'h0D: c = 8'h2B;
      7'h1A: c = 8'h7B;  7'h1B: c = 8'h7D;  7'h27: c = 8'h3A;  7'h28: c = 8'h22;
      7'h29: c = 8'h7E;  7'h2B: c = 8'h7C;  7'h33: c = 8'h3C;  7'h34: c = 8'h3E;
      7'h35: c = 8'h3F;
      default: c = (p >= CH_LOWER_A && p <= CH_LOWER_Z) ? p - CASE_DIFF : p;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/sle_ctrl.sv
`default_nettype none

module sle_ctrl
  import sle_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.op == OP_SCAN) begin
          unique case (status_i.act)
            ACT_BKSP: state_d = S_BS1;
            ACT_ECHO: state_d = S_ECHO;
            default:  state_d = S_IDLE;
          endcase
        end else begin
          unique case (status_i.rd)
            RD_EMPTY:  state_d = S_EMPTY;
            RD_STREAM: state_d = S_RD_ADDR;
            default:   state_d = S_NOTRDY;
          endcase
        end
      end
      S_BS1: begin
        if (status_i.out_free) state_d = S_BS2;
      end
      S_BS2: begin
        if (status_i.out_free) state_d = S_BS3;
      end
      S_ECHO, S_BS3, S_NOTRDY, S_EMPTY: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_RD_ADDR: state_d = S_RD_DATA;
      S_RD_DATA: begin
        if (status_i.out_free) state_d = status_i.idx_last ? S_IDLE : S_RD_ADDR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_src  = SRC_CHAR;
    in_stall_o     = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE:   cmd_o.accept = in_valid_i;
      S_DECODE: cmd_o.commit = 1'b1;
      S_ECHO: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_CHAR;
        cmd_o.out_last = 1'b1;
      end
      S_BS1: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_BS;
      end
      S_BS2: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_SPACE;
      end
      S_BS3: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_BS;
        cmd_o.out_last = 1'b1;
      end
      S_NOTRDY: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_NOTREADY;
        cmd_o.out_last = 1'b1;
      end
      S_EMPTY: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_EMPTY;
        cmd_o.out_last = 1'b1;
      end
      S_RD_ADDR: cmd_o.mem_rd = 1'b1;
      S_RD_DATA: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_src  = SRC_LINE;
        cmd_o.out_last = status_i.idx_last;
        cmd_o.idx_inc  = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/sle_datapath.sv
`default_nettype none

module sle_datapath
  import sle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_item_i,
  input  wire logic     out_stall_i,
  output logic          out_valid_o,
  output out_item_t     out_item_o,
  input  wire cmd_t     cmd_i,
  output status_t       status_o
);

  logic [7:0]       mem_q [BUFFER_DEPTH];
  logic [7:0]       rdata_q;

  in_item_t         item_q;
  logic [7:0]       char_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] idx_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic             done_q, done_d;
  logic             shift_q, shift_d;
  logic             caps_q, caps_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [6:0]        code;
  logic              release_key;
  logic              is_shift;
  logic [7:0]        plain;
  logic [7:0]        mapped;
  logic              full;
  act_e              act;
  logic              mem_we;
  logic [CALC_W-1:0] len_ext;
  logic [CALC_W-1:0] lim_m1;
  logic [CALC_W-1:0] n_min;
  logic [CNT_W-1:0]  n_sat;
  rd_e               rd;
  logic              out_free;
  out_item_t         out_new;

  assign code        = item_q.scan_byte[6:0];
  assign release_key = (item_q.scan_byte & REL_BIT) != 8'h00;
  assign is_shift    = (code == SC_LSHIFT) || (code == SC_RSHIFT);
  assign plain       = map_plain(code);
  assign full        = len_q >= LEN_W'(BUFFER_DEPTH - 1);

  // Letter case follows caps XOR shift; other keys follow shift alone.
  always_comb begin
    if (plain >= CH_LOWER_A && plain <= CH_LOWER_Z) begin
      mapped = (caps_q ^ shift_q) ? plain - CASE_DIFF : plain;
    end else begin
      mapped = shift_q ? map_shifted(code) : plain;
    end
  end

  always_comb begin
    act = ACT_NONE;
    if (release_key || is_shift || code == SC_CTRL || code == SC_ALT ||
        code == SC_CAPS) begin
      act = ACT_NONE;
    end else if (mapped == CH_BS) begin
      act = (len_q == '0 || done_q) ? ACT_NONE : ACT_BKSP;
    end else if (mapped == CH_NL) begin
      act = done_q ? ACT_NONE : ACT_ECHO;
    end else if (mapped != 8'h00 && !done_q && !full) begin
      act = ACT_ECHO;
    end
  end

  // Byte count of a read: the stored length, capped by limit minus one and
  // by the width of the count field.
  assign len_ext = CALC_W'(len_q);
  assign lim_m1  = CALC_W'(item_q.read_limit) - CALC_W'(1);
  always_comb begin
    if (item_q.read_limit == 7'd0) begin
      n_min = '0;
    end else begin
      n_min = (len_ext > lim_m1) ? lim_m1 : len_ext;
    end
    n_sat = (n_min > CALC_W'(MAX_COUNT)) ? MAX_COUNT : n_min[CNT_W-1:0];
  end

  always_comb begin
    if (!done_q)            rd = RD_NOTREADY;
    else if (n_sat == '0)   rd = RD_EMPTY;
    else                    rd = RD_STREAM;
  end

  always_comb begin
    len_d   = len_q;
    done_d  = done_q;
    shift_d = shift_q;
    caps_d  = caps_q;
    mem_we  = 1'b0;
    if (cmd_i.commit) begin
      if (item_q.opcode == OP_SCAN) begin
        if (release_key) begin
          if (is_shift) shift_d = 1'b0;
        end else if (is_shift) begin
          shift_d = 1'b1;
        end else if (code == SC_CAPS) begin
          caps_d = ~caps_q;
        end else if (act == ACT_BKSP) begin
          len_d = len_q - LEN_W'(1);
        end else if (act == ACT_ECHO) begin
          if (mapped == CH_NL) begin
            done_d = 1'b1;
            if (!full) begin
              mem_we = 1'b1;
              len_d  = len_q + LEN_W'(1);
            end
          end else begin
            mem_we = 1'b1;
            len_d  = len_q + LEN_W'(1);
          end
        end
      end else if (done_q) begin
        len_d  = '0;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      done_q  <= 1'b0;
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      done_q  <= done_d;
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[len_q] <= mapped;
    if (cmd_i.mem_rd) rdata_q <= mem_q[LEN_W'(idx_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_item_i;
    if (cmd_i.commit) begin
      char_q <= mapped;
      cnt_q  <= n_sat;
      idx_q  <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_new            = '0;
    out_new.last       = cmd_i.out_last;
    unique case (cmd_i.out_src)
      SRC_CHAR: begin
        out_new.kind      = KIND_ECHO;
        out_new.char_code = char_q;
      end
      SRC_BS: begin
        out_new.kind      = KIND_ECHO;
        out_new.char_code = CH_BS;
      end
      SRC_SPACE: begin
        out_new.kind      = KIND_ECHO;
        out_new.char_code = CH_SPACE;
      end
      SRC_NOTREADY: out_new.kind = KIND_NOTREADY;
      SRC_EMPTY:    out_new.kind = KIND_EMPTY;
      SRC_LINE: begin
        out_new.kind       = KIND_LINE;
        out_new.char_code  = rdata_q;
        out_new.line_count = cnt_q;
      end
      default: out_new.kind = KIND_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_new;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.op       = item_q.opcode;
  assign status_o.act      = act;
  assign status_o.rd       = rd;
  assign status_o.idx_last = (CALC_W'(idx_q) + CALC_W'(1)) == CALC_W'(cnt_q);
  assign status_o.out_free = out_free;

endmodule

`default_nettype wire

FILE: design/scancode_line_editor.sv
// Line editor fed by PS/2 set-1 scancodes.
// Input channel (in_valid_i / in_stall_o / in_item_i): each transaction is a
// scancode event or a request to read the completed line. One transaction is
// worked on at a time; in_stall_o is high from the cycle after acceptance
// until the last result of that transaction sits in the output register.
// Output channel (out_valid_o / out_stall_i / out_item_o): results leave a
// single output register while the receiver takes them.
// Steps from acceptance until the last result enters the output register:
// a scancode is decoded, then each echoed character (none, one, or three
// for a backspace) is loaded in turn. A read that streams n bytes, up to 63,
// fetches each byte from the registered line memory before it is loaded
// into the output register. Not-ready and empty reads give one result. The
// next transaction is accepted only once the controller is idle again.
// When the receiver stalls, the output register holds its transaction and
// the controller waits; nothing is dropped. Reset clears the line length,
// the line-closed flag, shift and caps lock, and the output valid; the line
// memory itself is not cleared, since only bytes written since the last
// clear are ever read back.
`default_nettype none

module scancode_line_editor
  import sle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the line memory, the editor state and the output
  // register that parts the two channels.
  sle_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  // Make codes and control characters that the package does not name.
  localparam logic [6:0] KEY_BKSP  = 7'h0E;
  localparam logic [6:0] KEY_ENTER = 7'h1C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  // Number of keystroke and read transactions that the stimulus aims for.
  localparam int unsigned KEY_TARGET = 360;

  // Clock and reset. The reset starts asserted so that the driver and the
  // monitor run their reset branches on the first rising edge.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Input channel, driven by the keystroke driver below.
  logic     in_valid = 1'b0;
  in_item_t in_item  = '0;
  logic     in_stall;

  // Output channel, sampled by the echo monitor below.
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  scancode_line_editor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Transactions waiting to be offered to the block, and the echoes and line
  // bytes that the block is expected to produce, oldest first.
  in_item_t  keystroke_q[$];
  out_item_t echo_and_line_q[$];

  int unsigned mismatches = 0;

  // Private copy of the editor state, advanced once per accepted transaction.
  logic [7:0]  line_buf [BUFFER_DEPTH];
  int unsigned line_len    = 0;
  logic        line_closed = 1'b0;
  logic        shift_down  = 1'b0;
  logic        caps_latched = 1'b0;

  // Shift state as the stimulus sees it, so that presses and releases pair up.
  logic stim_shift = 1'b0;

  // When calm is set, neither side idles or stalls; it flips now and then so
  // that the run has stretches at full rate between the noisy ones.
  logic calm = 1'b0;

  // Translates a make code into the character that the editor would see.
  // Each table entry holds the plain character in its upper byte and the
  // shifted one in its lower byte. Letters follow caps lock XOR shift; every
  // other key follows shift alone.
  function automatic logic [7:0] key_to_char(input logic [6:0] code, input logic shift,
                                             input logic caps);
    logic [15:0] pair;
    logic [7:0]  plain;
    logic [7:0]  upper;
    case (code)
      7'h01: pair = {CH_ESC, CH_ESC};
      7'h02: pair = "1!";  7'h03: pair = "2@";  7'h04: pair = "3#";  7'h05: pair = "4$";
      7'h06: pair = "5%";  7'h07: pair = "6^";  7'h08: pair = "7&";  7'h09: pair = "8*";
      7'h0A: pair = "9(";  7'h0B: pair = "0)";  7'h0C: pair = "-_";  7'h0D: pair = "=+";
      KEY_BKSP: pair = {CH_BS, CH_BS};
      7'h0F: pair = {CH_TAB, CH_TAB};
      7'h10: pair = "qQ";  7'h11: pair = "wW";  7'h12: pair = "eE";  7'h13: pair = "rR";
      7'h14: pair = "tT";  7'h15: pair = "yY";  7'h16: pair = "uU";  7'h17: pair = "iI";
      7'h18: pair = "oO";  7'h19: pair = "pP";  7'h1A: pair = "[{";  7'h1B: pair = "]}";
      KEY_ENTER: pair = {CH_NL, CH_NL};
      7'h1E: pair = "aA";  7'h1F: pair = "sS";  7'h20: pair = "dD";  7'h21: pair = "fF";
      7'h22: pair = "gG";  7'h23: pair = "hH";  7'h24: pair = "jJ";  7'h25: pair = "kK";
      7'h26: pair = "lL";  7'h27: pair = ";:";  7'h28: pair = "'\"";  7'h29: pair = "`~";
      7'h2B: pair = "\\|";  7'h2C: pair = "zZ";  7'h2D: pair = "xX";  7'h2E: pair = "cC";
      7'h2F: pair = "vV";  7'h30: pair = "bB";  7'h31: pair = "nN";  7'h32: pair = "mM";
      7'h33: pair = ",<";  7'h34: pair = ".>";  7'h35: pair = "/?";
      7'h39: pair = {CH_SPACE, CH_SPACE};
      default: pair = 16'h0000;
    endcase
    plain = pair[15:8];
    upper = pair[7:0];
    if (plain >= CH_LOWER_A && plain <= CH_LOWER_Z) begin
      return (caps ^ shift) ? upper : plain;
    end
    return shift ? upper : plain;
  endfunction

  function automatic out_item_t result_of(input logic [1:0] kind, input logic [7:0] ch,
                                          input logic [CNT_W-1:0] cnt, input logic last);
    out_item_t r;
    r.kind       = kind;
    r.char_code  = ch;
    r.line_count = cnt;
    r.last       = last;
    return r;
  endfunction

  // Advances the private editor state by one accepted transaction and queues
  // every result that it should cause.
  task automatic editor_step(input in_item_t it);
    logic [6:0]  code;
    logic [7:0]  ch;
    int unsigned n;
    code = it.scan_byte[6:0];
    if (it.opcode == OP_SCAN) begin
      if ((it.scan_byte & REL_BIT) != 8'h00) begin
        // Of all key releases only the two shift keys matter.
        if (code == SC_LSHIFT || code == SC_RSHIFT) begin
          shift_down = 1'b0;
        end
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_down = 1'b1;
      end else if (code == SC_CTRL || code == SC_ALT) begin
        // Ctrl and alt are not tracked at all.
      end else if (code == SC_CAPS) begin
        caps_latched = ~caps_latched;
      end else begin
        ch = key_to_char(code, shift_down, caps_latched);
        if (ch == CH_BS) begin
          // Rubs out the last character on screen; nothing to do on an empty
          // or a closed line.
          if (line_len != 0 && !line_closed) begin
            line_len--;
            echo_and_line_q.push_back(result_of(KIND_ECHO, CH_BS, '0, 1'b0));
            echo_and_line_q.push_back(result_of(KIND_ECHO, CH_SPACE, '0, 1'b0));
            echo_and_line_q.push_back(result_of(KIND_ECHO, CH_BS, '0, 1'b1));
          end
        end else if (ch == CH_NL) begin
          // Enter closes the line. On a full line it is echoed but not stored.
          if (!line_closed) begin
            if (line_len < BUFFER_DEPTH - 1) begin
              line_buf[line_len] = CH_NL;
              line_len++;
            end
            line_closed = 1'b1;
            echo_and_line_q.push_back(result_of(KIND_ECHO, CH_NL, '0, 1'b1));
          end
        end else if (ch != 8'h00 && !line_closed && line_len < BUFFER_DEPTH - 1) begin
          line_buf[line_len] = ch;
          line_len++;
          echo_and_line_q.push_back(result_of(KIND_ECHO, ch, '0, 1'b1));
        end
      end
    end else if (!line_closed) begin
      // Nothing to hand out yet; the open line is left alone.
      echo_and_line_q.push_back(result_of(KIND_NOTREADY, 8'h00, '0, 1'b1));
    end else begin
      // The caller's buffer keeps one byte back, and the count saturates at
      // the width of line_count.
      n = line_len;
      if (it.read_limit == 0) begin
        n = 0;
      end else if (n > it.read_limit - 1) begin
        n = it.read_limit - 1;
      end
      if (n > MAX_COUNT) begin
        n = MAX_COUNT;
      end
      line_len    = 0;
      line_closed = 1'b0;
      if (n == 0) begin
        echo_and_line_q.push_back(result_of(KIND_EMPTY, 8'h00, '0, 1'b1));
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          echo_and_line_q.push_back(result_of(KIND_LINE, line_buf[i], CNT_W'(n),
                                              i + 1 == n));
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Compares one accepted result with the oldest expected one, field by field.
  task automatic check_echo(input out_item_t got);
    out_item_t want;
    if (echo_and_line_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d char %02h count %0d last %0d",
                              got.kind, got.char_code, got.line_count, got.last));
      return;
    end
    want = echo_and_line_q.pop_front();
    if (got.kind !== want.kind) begin
      flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    end
    if (got.char_code !== want.char_code) begin
      flag_mismatch($sformatf("char_code %02h, expected %02h", got.char_code,
                              want.char_code));
    end
    if (got.line_count !== want.line_count) begin
      flag_mismatch($sformatf("line_count %0d, expected %0d", got.line_count,
                              want.line_count));
    end
    if (got.last !== want.last) begin
      flag_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    end
  endtask

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Unused fields of every transaction carry random values, so that every
  // input bit toggles whatever the opcode.
  task automatic queue_scan(input logic [7:0] sc);
    in_item_t it;
    it.opcode     = OP_SCAN;
    it.scan_byte  = sc;
    it.read_limit = 7'($urandom_range(0, 64));
    keystroke_q.push_back(it);
  endtask

  task automatic queue_read(input logic [6:0] lim);
    in_item_t it;
    it.opcode     = OP_READ;
    it.scan_byte  = 8'($urandom_range(0, 255));
    it.read_limit = lim;
    keystroke_q.push_back(it);
  endtask

  // A make code that types a character: no modifier, backspace or enter.
  function automatic logic [7:0] pick_typed_key();
    logic [6:0] k;
    do begin
      k = 7'($urandom_range(1, 7'h39));
    end while (k == SC_LSHIFT || k == SC_RSHIFT || k == SC_CTRL || k == SC_ALT ||
               k == KEY_BKSP || k == KEY_ENTER || key_to_char(k, 1'b0, 1'b0) == 8'h00);
    return {1'b0, k};
  endfunction

  // Read limit: the full buffer most often, the degenerate sizes sometimes.
  function automatic logic [6:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 7'd64;
    if (r < 65) return 7'($urandom_range(0, 64));
    if (r < 75) return 7'($urandom_range(0, 1));
    return 7'($urandom_range(2, 12));
  endfunction

  task automatic press_or_release_shift();
    logic [6:0] key;
    key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    queue_scan(stim_shift ? (REL_BIT | {1'b0, key}) : {1'b0, key});
    stim_shift = ~stim_shift;
  endtask

  // One well-formed editing session: typing with the odd correction and
  // modifier, enter, maybe some keys on the closed line, then a read.
  task automatic type_line(input int unsigned len);
    int unsigned r;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        queue_scan(pick_typed_key());
      end else if (r < 80) begin
        queue_scan({1'b0, KEY_BKSP});
      end else if (r < 86) begin
        press_or_release_shift();
      end else if (r < 89) begin
        queue_scan({1'b0, SC_CAPS});
      end else if (r < 93) begin
        queue_scan(REL_BIT | 8'($urandom_range(0, 127)));
      end else if (r < 96) begin
        queue_scan({1'b0, ($urandom_range(0, 1) ? SC_CTRL : SC_ALT)});
      end else begin
        queue_scan(8'($urandom_range(0, 255)));
      end
    end
    if (stim_shift) begin
      press_or_release_shift();
    end
    queue_scan({1'b0, KEY_ENTER});
    if ($urandom_range(0, 3) == 0) begin
      queue_scan(pick_typed_key());
      queue_scan({1'b0, KEY_BKSP});
      queue_scan({1'b0, KEY_ENTER});
    end
    queue_read(pick_limit());
  endtask

  // Keystroke driver. A payload stays put while the block stalls; after each
  // accepted transaction the valid may drop for a random number of cycles.
  int unsigned key_hold = 0;
  wire         key_fire = in_valid && !in_stall;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      key_hold <= 0;
    end else begin
      if (key_fire) begin
        editor_step(in_item);
        if ($urandom_range(0, 49) == 0) begin
          calm <= ~calm;
        end
      end
      if (!in_valid || key_fire) begin
        if (key_hold != 0) begin
          in_valid <= 1'b0;
          key_hold <= key_hold - 1;
        end else if (keystroke_q.size() != 0) begin
          in_item  <= keystroke_q.pop_front();
          in_valid <= 1'b1;
          key_hold <= calm ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Echo monitor. Checks each transaction taken from the output channel and
  // then decides whether to stall on the next cycle.
  int unsigned echo_hold = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      echo_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_echo(out_item);
      end
      if (echo_hold != 0) begin
        out_stall <= 1'b1;
        echo_hold <= echo_hold - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        echo_hold <= idle_len();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Safety net against a hung block. The slowest correct run, with every
  // transaction a full read under the longest stalls, stays well below this.
  initial begin
    #160_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned r;

    // Directed part: each editing rule once, with the field extremes.
    queue_read(7'd64);                      // read with no line ready
    queue_scan(8'h00);                      // code that maps to nothing
    queue_scan(8'h7F);
    queue_scan({1'b0, KEY_BKSP});           // backspace on an empty line
    queue_scan({1'b0, SC_CTRL});
    queue_scan({1'b0, SC_ALT});
    queue_scan(8'h1E);                      // a
    queue_scan({1'b0, SC_LSHIFT});
    queue_scan(8'h1E);                      // A
    queue_scan(8'h02);                      // !
    queue_scan(REL_BIT | {1'b0, SC_LSHIFT});
    queue_scan({1'b0, SC_CAPS});
    queue_scan(8'h1E);                      // A from caps lock
    queue_scan({1'b0, SC_RSHIFT});
    queue_scan(8'h1E);                      // caps and shift cancel: a
    queue_scan(REL_BIT | {1'b0, SC_RSHIFT});
    queue_scan({1'b0, SC_CAPS});
    queue_scan(8'hFF);                      // release of a key that is ignored
    queue_scan(8'h80);
    queue_scan({1'b0, KEY_BKSP});           // rub out one character
    queue_scan({1'b0, KEY_ENTER});
    queue_scan({1'b0, KEY_ENTER});          // enter on a closed line
    queue_scan(8'h10);                      // character on a closed line
    queue_scan({1'b0, KEY_BKSP});           // backspace on a closed line
    queue_read(7'd1);                       // zero-byte read, still clears
    queue_scan(8'h10);
    queue_scan({1'b0, KEY_ENTER});
    queue_read(7'd0);
    queue_scan(8'h11);
    queue_scan({1'b0, KEY_ENTER});
    queue_read(7'd2);                       // one byte of two

    // A line that overflows: extra characters drop and enter is not stored.
    for (int unsigned i = 0; i < 66; i++) begin
      queue_scan(pick_typed_key());
    end
    queue_scan({1'b0, KEY_ENTER});
    queue_read(7'd64);
    // A line that exactly fills the store, enter included.
    for (int unsigned i = 0; i < 62; i++) begin
      queue_scan(pick_typed_key());
    end
    queue_scan({1'b0, KEY_ENTER});
    queue_read(7'd64);

    // Random part: mostly editing sessions, mostly short lines, with some
    // stray reads and raw scancodes in between.
    while (keystroke_q.size() < KEY_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        type_line(($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                : $urandom_range(30, 70));
      end else if (r < 90) begin
        queue_read(7'($urandom_range(0, 64)));
      end else begin
        queue_scan(8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to be taken and every result to come back,
    // then give the block time to show any stray extra result.
    while (keystroke_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (echo_and_line_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);

    if (mismatches == 0 && echo_and_line_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
